FILE: rtl/core/pfb_pkg.sv
// Shared types and constants for the page framebuffer blitter.
`default_nettype none

package pfb_pkg;

  localparam int DEF_SCREEN_COLUMNS = 128;
  localparam int DEF_SCREEN_PAGES   = 8;

  localparam int QUEUE_DEPTH = 4;

  // input opcodes
  localparam logic [2:0] OP_FILL    = 3'd0;
  localparam logic [2:0] OP_PIXEL   = 3'd1;
  localparam logic [2:0] OP_BEGIN   = 3'd2;
  localparam logic [2:0] OP_DATA    = 3'd3;
  localparam logic [2:0] OP_PRESENT = 3'd4;

  typedef enum logic [2:0] {
    CMD_FILL,
    CMD_PIXEL,
    CMD_BEGIN,
    CMD_DATA,
    CMD_PRESENT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [6:0]  pos_x;
    logic [5:0]  pos_y;
    logic [7:0]  blit_width;
    logic [6:0]  blit_height;
    logic [7:0]  value_byte;
    logic [2:0]  page_select;
  } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/pfb_if.sv
// Valid/ready channel interfaces for commands and presented column pairs.
`default_nettype none

interface pfb_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [6:0] pos_x;
  logic [5:0] pos_y;
  logic [7:0] blit_width;
  logic [6:0] blit_height;
  logic [7:0] value_byte;
  logic [2:0] page_select;

  modport source (
    output valid, opcode, pos_x, pos_y, blit_width, blit_height, value_byte, page_select,
    input  ready
  );
  modport sink (
    input  valid, opcode, pos_x, pos_y, blit_width, blit_height, value_byte, page_select,
    output ready
  );
endinterface

interface pfb_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] out_page;
  logic [5:0] out_column;
  logic [7:0] left_byte;
  logic [7:0] right_byte;
  logic       last_of_page;

  modport source (
    output valid, out_page, out_column, left_byte, right_byte, last_of_page,
    input  ready
  );
  modport sink (
    input  valid, out_page, out_column, left_byte, right_byte, last_of_page,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/pfb_front.sv
// Command front end: decodes opcodes and drops commands with no effect.
`default_nettype none

module pfb_front import pfb_pkg::*; #(
  parameter int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
  parameter int SCREEN_PAGES   = DEF_SCREEN_PAGES
) (
  pfb_in_if.sink     in_ch,
  input  wire logic  clearing,
  input  wire logic  q_full,
  output logic       q_push,
  output cmd_t       q_cmd
);

  localparam int ScreenRows = SCREEN_PAGES * 8;

  logic keep;

  assign in_ch.ready = !q_full && !clearing;

  always_comb begin
    q_cmd.pos_x       = in_ch.pos_x;
    q_cmd.pos_y       = in_ch.pos_y;
    q_cmd.blit_width  = in_ch.blit_width;
    q_cmd.blit_height = in_ch.blit_height;
    q_cmd.value_byte  = in_ch.value_byte;
    q_cmd.page_select = in_ch.page_select;
    q_cmd.kind        = CMD_FILL;
    keep              = 1'b0;
    unique case (in_ch.opcode)
      OP_FILL: begin
        q_cmd.kind = CMD_FILL;
        keep       = 1'b1;
      end
      OP_PIXEL: begin
        // off-screen pixels never touch the store
        q_cmd.kind = CMD_PIXEL;
        keep       = (int'(in_ch.pos_x) < SCREEN_COLUMNS) && (int'(in_ch.pos_y) < ScreenRows);
      end
      OP_BEGIN: begin
        q_cmd.kind = CMD_BEGIN;
        keep       = 1'b1;
      end
      OP_DATA: begin
        q_cmd.kind = CMD_DATA;
        keep       = 1'b1;
      end
      OP_PRESENT: begin
        q_cmd.kind = CMD_PRESENT;
        keep       = int'(in_ch.page_select) < SCREEN_PAGES;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign q_push = in_ch.valid && in_ch.ready && keep;

endmodule

`default_nettype wire

FILE: rtl/core/pfb_cmd_queue.sv
// Short command queue between the front end and the execution engine.
`default_nettype none

module pfb_cmd_queue import pfb_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire cmd_t  push_cmd,
  output logic       full,
  output logic       head_valid,
  output cmd_t       head_cmd,
  input  wire logic  pop
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            entry_r [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] rd_ptr_r;
  logic [CntW-1:0] count_r;
  logic            do_push;
  logic            do_pop;

  assign full       = (count_r == CntW'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = entry_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/pfb_back.sv
// Execution engine: frame store, fill sweep, pixel and blit RMW, page readout.
`default_nettype none

module pfb_back import pfb_pkg::*; #(
  parameter int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
  parameter int SCREEN_PAGES   = DEF_SCREEN_PAGES
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_valid,
  input  wire cmd_t  q_cmd,
  output logic       q_pop,
  output logic       clearing,
  pfb_out_if.source  out_ch
);

  localparam int ScreenRows = SCREEN_PAGES * 8;
  localparam int StoreBytes = SCREEN_PAGES * SCREEN_COLUMNS;
  localparam int HalfCols   = SCREEN_COLUMNS / 2;
  localparam int AddrW      = $clog2(StoreBytes);
  localparam int ColW       = $clog2(HalfCols);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_BLIT,
    ST_PRESENT
  } state_t;

  function automatic logic [AddrW-1:0] pix_addr(input logic [8:0] x, input logic [7:0] y);
    return AddrW'(y[7:3]) * AddrW'(SCREEN_COLUMNS) + AddrW'(x);
  endfunction

  logic [7:0] frame_mem [StoreBytes];

  state_t           state_r;
  logic             clearing_r;
  logic [AddrW-1:0] fill_ptr_r;
  logic [7:0]       fill_val_r;

  logic [6:0]       org_x_r;
  logic [5:0]       org_y_r;
  logic [7:0]       cols_r;
  logic [6:0]       rows_r;
  logic [7:0]       cur_col_r;
  logic [6:0]       cur_row_r;
  logic [7:0]       bits_r;
  logic [2:0]       bit_r;

  logic             wb_valid_r;
  logic [AddrW-1:0] wb_addr_r;
  logic [2:0]       wb_bit_r;
  logic             wb_on_r;
  logic             fwd_r;
  logic [7:0]       last_wd_r;

  logic [2:0]       page_r;
  logic [AddrW-1:0] base_r;
  logic [ColW-1:0]  k_r;
  logic             pv_r;
  logic [ColW-1:0]  pk_r;
  logic [7:0]       qa_r;
  logic [7:0]       qb_r;

  logic             out_valid_r;
  logic [2:0]       out_page_r;
  logic [5:0]       out_column_r;
  logic [7:0]       left_r;
  logic [7:0]       right_r;
  logic             last_r;

  logic             take;
  logic             move;
  logic             issue;
  logic [8:0]       blit_x;
  logic [7:0]       blit_y;
  logic             blit_live;
  logic             blit_in;
  logic [7:0]       col_inc;
  logic             rea;
  logic             reb;
  logic [AddrW-1:0] ra;
  logic [AddrW-1:0] rb;
  logic             we;
  logic [AddrW-1:0] wa;
  logic [7:0]       wd;
  logic [7:0]       rmw_base;
  logic [7:0]       rmw_mask;
  logic [7:0]       rmw_data;

  // new command only once pending writes and readouts have drained
  assign take  = (state_r == ST_IDLE) && !wb_valid_r && !pv_r && q_valid;
  assign q_pop = take;
  assign move  = pv_r && (!out_valid_r || out_ch.ready);
  assign issue = (state_r == ST_PRESENT) && (!pv_r || move);

  assign blit_x    = 9'(org_x_r) + 9'(cur_col_r);
  assign blit_y    = 8'(org_y_r) + 8'(cur_row_r);
  assign blit_live = (cols_r != 8'd0) && (cur_row_r < rows_r);
  assign blit_in   = (int'(blit_x) < SCREEN_COLUMNS) && (int'(blit_y) < ScreenRows);
  assign col_inc   = cur_col_r + 8'd1;

  // the registered read misses a write to the same address in the same cycle, so bypass it
  assign rmw_base = fwd_r ? last_wd_r : qa_r;
  assign rmw_mask = 8'd1 << wb_bit_r;
  assign rmw_data = wb_on_r ? (rmw_base | rmw_mask) : (rmw_base & ~rmw_mask);

  always_comb begin
    rea = 1'b0;
    reb = 1'b0;
    ra  = pix_addr(blit_x, blit_y);
    rb  = base_r + AddrW'(HalfCols) + AddrW'(k_r);
    if (take && (q_cmd.kind == CMD_PIXEL)) begin
      rea = 1'b1;
      ra  = pix_addr(9'(q_cmd.pos_x), 8'(q_cmd.pos_y));
    end else if ((state_r == ST_BLIT) && blit_live && blit_in) begin
      rea = 1'b1;
    end else if (issue) begin
      rea = 1'b1;
      reb = 1'b1;
      ra  = base_r + AddrW'(k_r);
    end
  end

  always_comb begin
    if (state_r == ST_FILL) begin
      we = 1'b1;
      wa = fill_ptr_r;
      wd = fill_val_r;
    end else begin
      we = wb_valid_r;
      wa = wb_addr_r;
      wd = rmw_data;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      frame_mem[wa] <= wd;
    end
    if (rea) begin
      qa_r <= frame_mem[ra];
    end
    if (reb) begin
      qb_r <= frame_mem[rb];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      clearing_r  <= 1'b1;
      fill_ptr_r  <= '0;
      fill_val_r  <= 8'd0;
      org_x_r     <= '0;
      org_y_r     <= '0;
      cols_r      <= '0;
      rows_r      <= '0;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      wb_valid_r  <= 1'b0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fwd_r      <= wb_valid_r && (wb_addr_r == ra);
      last_wd_r  <= rmw_data;
      wb_valid_r <= 1'b0;

      if (move) begin
        out_valid_r  <= 1'b1;
        out_page_r   <= page_r;
        out_column_r <= 6'(pk_r);
        left_r       <= qa_r;
        right_r      <= qb_r;
        last_r       <= (pk_r == ColW'(HalfCols - 1));
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      if (issue) begin
        pv_r <= 1'b1;
        pk_r <= k_r;
      end else if (move) begin
        pv_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (take) begin
            unique case (q_cmd.kind)
              CMD_FILL: begin
                fill_val_r <= q_cmd.value_byte;
                fill_ptr_r <= '0;
                state_r    <= ST_FILL;
              end
              CMD_PIXEL: begin
                wb_valid_r <= 1'b1;
                wb_addr_r  <= ra;
                wb_bit_r   <= q_cmd.pos_y[2:0];
                wb_on_r    <= (q_cmd.value_byte != 8'd0);
              end
              CMD_BEGIN: begin
                org_x_r   <= q_cmd.pos_x;
                org_y_r   <= q_cmd.pos_y;
                cols_r    <= q_cmd.blit_width;
                rows_r    <= q_cmd.blit_height;
                cur_col_r <= '0;
                cur_row_r <= '0;
              end
              CMD_DATA: begin
                bits_r  <= q_cmd.value_byte;
                bit_r   <= 3'd7;
                state_r <= ST_BLIT;
              end
              CMD_PRESENT: begin
                page_r  <= q_cmd.page_select;
                base_r  <= AddrW'(q_cmd.page_select) * AddrW'(SCREEN_COLUMNS);
                k_r     <= '0;
                state_r <= ST_PRESENT;
              end
            endcase
          end
        end
        ST_FILL: begin
          fill_ptr_r <= fill_ptr_r + AddrW'(1);
          if (fill_ptr_r == AddrW'(StoreBytes - 1)) begin
            clearing_r <= 1'b0;
            state_r    <= ST_IDLE;
          end
        end
        ST_BLIT: begin
          if (!blit_live) begin
            // blit finished or never begun: rest of the byte is ignored
            state_r <= ST_IDLE;
          end else begin
            if (blit_in) begin
              wb_valid_r <= 1'b1;
              wb_addr_r  <= ra;
              wb_bit_r   <= blit_y[2:0];
              wb_on_r    <= bits_r[bit_r];
            end
            if (col_inc >= cols_r) begin
              cur_col_r <= '0;
              cur_row_r <= cur_row_r + 7'd1;
            end else begin
              cur_col_r <= col_inc;
            end
            if (bit_r == 3'd0) begin
              state_r <= ST_IDLE;
            end else begin
              bit_r <= bit_r - 3'd1;
            end
          end
        end
        ST_PRESENT: begin
          if (issue) begin
            k_r <= k_r + ColW'(1);
            if (k_r == ColW'(HalfCols - 1)) begin
              state_r <= ST_IDLE;
            end
          end
        end
      endcase
    end
  end

  assign clearing            = clearing_r;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_page     = out_page_r;
  assign out_ch.out_column   = out_column_r;
  assign out_ch.left_byte    = left_r;
  assign out_ch.right_byte   = right_r;
  assign out_ch.last_of_page = last_r;

endmodule

`default_nettype wire

FILE: rtl/core/page_framebuffer_blitter.sv
// Page framebuffer blitter: 128x64 monochrome store with blit and page readout.
// Usage:
//   in_ch carries commands (fill, set pixel, begin blit, blit data byte,
//   present page) on a valid/ready handshake; out_ch carries column pairs
//   of a presented page, left half and right half together.
// Steps per command, after it reaches the head of the 4-entry queue:
//   fill          decode, then one store byte per cycle over all
//                 SCREEN_PAGES*SCREEN_COLUMNS store bytes
//   set pixel     read, then modify-write on the single write port
//   begin blit    loads origin and size, resets the blit cursor
//   blit byte     decode, one pixel read-modify-write per bit,
//                 then drain of the last write
//   present page  SCREEN_COLUMNS/2 results, one per cycle while the receiver
//                 is ready, read from the dual read ports
// Commands with no effect (off-screen pixel, page out of range, unused
// opcode) are dropped at the front and cost nothing downstream.
// Reset: the store is cleared by a sweep over all SCREEN_PAGES*SCREEN_COLUMNS
// bytes (1024 by default); in_ch.ready stays low until it completes.
// A stalled receiver holds the present stream in the output register; the
// queue keeps accepting until it is full.
`default_nettype none

module page_framebuffer_blitter import pfb_pkg::*; #(
  parameter int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
  parameter int SCREEN_PAGES   = DEF_SCREEN_PAGES
) (
  input  wire logic clk,
  input  wire logic rst_n,
  pfb_in_if.sink    in_ch,
  pfb_out_if.source out_ch
);

  logic clearing;
  logic q_full;
  logic q_push;
  cmd_t q_push_cmd;
  logic q_valid;
  cmd_t q_head;
  logic q_pop;

  pfb_front #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_PAGES   (SCREEN_PAGES)
  ) u_front (
    .in_ch    (in_ch),
    .clearing (clearing),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_push_cmd)
  );

  pfb_cmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_push_cmd),
    .full       (q_full),
    .head_valid (q_valid),
    .head_cmd   (q_head),
    .pop        (q_pop)
  );

  pfb_back #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_PAGES   (SCREEN_PAGES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_cmd    (q_head),
    .q_pop    (q_pop),
    .clearing (clearing),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

FILE: rtl/core/pfb_checker.sv
// Port-level assertions for the page framebuffer blitter, bound to the top level.
`default_nettype none

module pfb_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] out_page,
  input wire logic [5:0] out_column,
  input wire logic [7:0] left_byte,
  input wire logic [7:0] right_byte,
  input wire logic       last_of_page
);

  // store clearing and empty output after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("ready or valid high straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_page) && $stable(out_column)
      && $stable(left_byte) && $stable(right_byte) && $stable(last_of_page))
    else $error("stalled result changed");

  // a page streams without gaps until its last column
  a_stream_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last_of_page |=> out_valid)
    else $error("gap inside a page transfer");

  a_column_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last_of_page |=>
      out_column == $past(out_column) + 6'd1 && out_page == $past(out_page))
    else $error("column or page out of sequence");

endmodule

bind page_framebuffer_blitter pfb_checker u_pfb_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_page     (out_ch.out_page),
  .out_column   (out_ch.out_column),
  .left_byte    (out_ch.left_byte),
  .right_byte   (out_ch.right_byte),
  .last_of_page (out_ch.last_of_page)
);

`default_nettype wire

FILE: tb/page_framebuffer_blitter_tb.sv
// Self-checking testbench for the page framebuffer blitter: drawing commands, page readout.
`timescale 1ns / 100ps

module page_framebuffer_blitter_tb;
  import pfb_pkg::*;

  localparam int COLS      = DEF_SCREEN_COLUMNS;
  localparam int PAGES     = DEF_SCREEN_PAGES;
  localparam int ROWS      = PAGES * 8;
  localparam int HALF      = COLS / 2;
  localparam int STORE_LEN = PAGES * COLS;

  typedef struct {
    logic [2:0] opcode;
    logic [6:0] pos_x;
    logic [5:0] pos_y;
    logic [7:0] blit_width;
    logic [6:0] blit_height;
    logic [7:0] value_byte;
    logic [2:0] page_select;
  } draw_cmd_t;

  typedef struct {
    logic [2:0] page;
    logic [5:0] column;
    logic [7:0] left_byte;
    logic [7:0] right_byte;
    logic       last;
  } column_pair_t;

  logic clk;
  logic rst_n;

  pfb_in_if  in_ch ();
  pfb_out_if out_ch ();

  page_framebuffer_blitter i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow framebuffer and blit cursor
  logic [7:0] shadow_fb [0:STORE_LEN-1];
  logic [6:0] blit_org_x;
  logic [5:0] blit_org_y;
  logic [7:0] blit_cols;
  logic [6:0] blit_rows;
  logic [7:0] blit_cur_col;
  logic [6:0] blit_cur_row;

  column_pair_t pending_pairs [$];

  int  mismatches = 0;
  int  cmds_sent  = 0;
  bit  steady     = 0;
  bit  rx_hold    = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(2_400_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------- prediction

  function automatic void shadow_reset();
    foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;
    blit_org_x   = '0;
    blit_org_y   = '0;
    blit_cols    = '0;
    blit_rows    = '0;
    blit_cur_col = '0;
    blit_cur_row = '0;
  endfunction

  function automatic void shadow_plot(int x, int y, bit on);
    int idx;
    if (x >= COLS || y >= ROWS) return;
    idx = (y / 8) * COLS + x;
    shadow_fb[idx][y % 8] = on;
  endfunction

  function automatic void shadow_blit_byte(logic [7:0] bits);
    for (int b = 7; b >= 0; b--) begin
      if (blit_cols == 0 || blit_cur_row >= blit_rows) return;
      shadow_plot(int'(blit_org_x) + int'(blit_cur_col),
                  int'(blit_org_y) + int'(blit_cur_row), bits[b]);
      if (int'(blit_cur_col) + 1 >= int'(blit_cols)) begin
        blit_cur_col = '0;
        blit_cur_row = blit_cur_row + 1'b1;
      end else begin
        blit_cur_col = blit_cur_col + 1'b1;
      end
    end
  endfunction

  function automatic void shadow_apply(draw_cmd_t c);
    column_pair_t pair;
    int base;
    case (c.opcode)
      OP_FILL: begin
        foreach (shadow_fb[i]) shadow_fb[i] = c.value_byte;
      end
      OP_PIXEL: shadow_plot(int'(c.pos_x), int'(c.pos_y), c.value_byte != 0);
      OP_BEGIN: begin
        blit_org_x   = c.pos_x;
        blit_org_y   = c.pos_y;
        blit_cols    = c.blit_width;
        blit_rows    = c.blit_height;
        blit_cur_col = '0;
        blit_cur_row = '0;
      end
      OP_DATA: shadow_blit_byte(c.value_byte);
      OP_PRESENT: begin
        if (int'(c.page_select) < PAGES) begin
          base = int'(c.page_select) * COLS;
          for (int k = 0; k < HALF; k++) begin
            pair.page       = c.page_select;
            pair.column     = k[5:0];
            pair.left_byte  = shadow_fb[base + k];
            pair.right_byte = shadow_fb[base + HALF + k];
            pair.last       = (k == HALF - 1);
            pending_pairs.push_back(pair);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= 40)
      $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  always @(posedge clk) begin : check_pairs
    column_pair_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_pairs.size() == 0) begin
        report_mismatch("transfer with nothing pending, column", out_ch.out_column, 0);
      end else begin
        want = pending_pairs.pop_front();
        if (out_ch.out_page !== want.page)
          report_mismatch("out_page", out_ch.out_page, want.page);
        if (out_ch.out_column !== want.column)
          report_mismatch("out_column", out_ch.out_column, want.column);
        if (out_ch.left_byte !== want.left_byte)
          report_mismatch("left_byte", out_ch.left_byte, want.left_byte);
        if (out_ch.right_byte !== want.right_byte)
          report_mismatch("right_byte", out_ch.right_byte, want.right_byte);
        if (out_ch.last_of_page !== want.last)
          report_mismatch("last_of_page", out_ch.last_of_page, want.last);
      end
    end
  end

  // receiver: random stalls, none while steady, solid hold-off on request
  always @(posedge clk) begin
    if (rx_hold)
      out_ch.ready <= 1'b0;
    else if (!steady && $urandom_range(99) < 9)
      out_ch.ready <= 1'b0;
    else
      out_ch.ready <= 1'b1;
  end

  task automatic hold_receiver(int cycles);
    @(negedge clk);
    rx_hold = 1'b1;
    repeat (cycles) @(posedge clk);
    @(negedge clk);
    rx_hold = 1'b0;
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic draw_cmd_t make_cmd(logic [2:0] op, int x = 0, int y = 0, int w = 0,
                                         int h = 0, int v = 0, int pg = 0);
    draw_cmd_t c;
    c.opcode      = op;
    c.pos_x       = x[6:0];
    c.pos_y       = y[5:0];
    c.blit_width  = w[7:0];
    c.blit_height = h[6:0];
    c.value_byte  = v[7:0];
    c.page_select = pg[2:0];
    return c;
  endfunction

  // drive one command and hold it until the transfer; valid is left high
  task automatic send_cmd(draw_cmd_t c);
    if (!steady && $urandom_range(99) < 9) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= c.opcode;
    in_ch.pos_x       <= c.pos_x;
    in_ch.pos_y       <= c.pos_y;
    in_ch.blit_width  <= c.blit_width;
    in_ch.blit_height <= c.blit_height;
    in_ch.value_byte  <= c.value_byte;
    in_ch.page_select <= c.page_select;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    shadow_apply(c);
    cmds_sent++;
  endtask

  // drop valid straight after the last transfer so nothing is taken twice
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_pairs.size() != 0) @(posedge clk);
  endtask

  task automatic test_after_reset();
    send_cmd(make_cmd(OP_DATA, .v(8'hFF)));      // no blit begun: ignored
    for (int op = OP_PRESENT + 1; op <= 7; op++)
      send_cmd(make_cmd(3'(op), $urandom_range(127), $urandom_range(63), 255, 127, 255, 7));
    send_cmd(make_cmd(OP_PRESENT, .pg(0)));
    send_cmd(make_cmd(OP_PRESENT, .pg(PAGES - 1)));
  endtask

  task automatic test_fill_and_pixel();
    send_cmd(make_cmd(OP_FILL, .v(8'hFF)));
    send_cmd(make_cmd(OP_PIXEL, 0, 0, .v(0)));
    send_cmd(make_cmd(OP_PIXEL, COLS - 1, ROWS - 1, .v(0)));
    send_cmd(make_cmd(OP_PRESENT, .pg(0)));
    send_cmd(make_cmd(OP_PRESENT, .pg(PAGES - 1)));
    send_cmd(make_cmd(OP_FILL, .v(8'h00)));
    send_cmd(make_cmd(OP_PIXEL, 0, 0, .v(8'h80)));
    send_cmd(make_cmd(OP_PIXEL, COLS - 1, ROWS - 1, .v(8'h01)));
    send_cmd(make_cmd(OP_PRESENT, .pg(0)));
    send_cmd(make_cmd(OP_PRESENT, .pg(PAGES - 1)));
  endtask

  task automatic test_blit_edges();
    // 3 wide, 6 tall near the corner: wraps rows, clips at the bottom
    send_cmd(make_cmd(OP_BEGIN, COLS - 6, ROWS - 4, 3, 6));
    send_cmd(make_cmd(OP_DATA, .v(8'hFF)));
    send_cmd(make_cmd(OP_DATA, .v(8'hA5)));
    send_cmd(make_cmd(OP_DATA, .v(8'h3C)));    // last bits past the end of the bitmap
    // empty blits
    send_cmd(make_cmd(OP_BEGIN, 0, 0, 0, ROWS));
    send_cmd(make_cmd(OP_DATA, .v(8'hFF)));
    send_cmd(make_cmd(OP_BEGIN, 0, 0, COLS, 0));
    send_cmd(make_cmd(OP_DATA, .v(8'hFF)));
    send_cmd(make_cmd(OP_PRESENT, .pg(PAGES - 1)));
  endtask

  task automatic run_blit_sequence();
    int w, h, x, y, nbytes, pick;
    pick = $urandom_range(99);
    x = $urandom_range(COLS - 1);
    y = $urandom_range(ROWS - 1);
    if (pick < 70) begin
      w = $urandom_range(1, 16);
      h = $urandom_range(1, 8);
    end else if (pick < 80) begin
      w = $urandom_range(129, 255);
      h = $urandom_range(1, 2);
    end else if (pick < 88) begin
      w = $urandom_range(1, 8);
      h = $urandom_range(65, 127);
    end else if (pick < 94) begin
      w = 0;
      h = $urandom_range(127);
    end else begin
      w = $urandom_range(16);
      h = 0;
    end
    nbytes = (w * h + 7) / 8;
    if (nbytes > 12) nbytes = 12;
    if (nbytes == 0) nbytes = $urandom_range(1, 3);
    // a few sequences are cut short or overrun
    case ($urandom_range(9))
      0: nbytes = nbytes / 2;
      1: nbytes = nbytes + 2;
      default: ;
    endcase
    send_cmd(make_cmd(OP_BEGIN, x, y, w, h));
    repeat (nbytes) send_cmd(make_cmd(OP_DATA, .v($urandom_range(255))));
    if ($urandom_range(99) < 60)
      send_cmd(make_cmd(OP_PRESENT, .pg(y / 8)));
  endtask

  task automatic run_random_traffic(int stop_at);
    int r;
    while (cmds_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 45)
        run_blit_sequence();
      else if (r < 62)
        send_cmd(make_cmd(OP_PIXEL, $urandom_range(COLS - 1), $urandom_range(ROWS - 1),
                          .v(($urandom_range(9) < 4) ? 0 : $urandom_range(1, 255))));
      else if (r < 82)
        send_cmd(make_cmd(OP_PRESENT, .pg($urandom_range(PAGES - 1))));
      else if (r < 85)
        send_cmd(make_cmd(OP_FILL, .v($urandom_range(255))));
      else if (r < 92)
        send_cmd(make_cmd(OP_DATA, .v($urandom_range(255))));
      else
        send_cmd(make_cmd(3'($urandom_range(7, OP_PRESENT + 1)), $urandom_range(127),
                          $urandom_range(63), $urandom_range(255), $urandom_range(127),
                          $urandom_range(255), $urandom_range(7)));
    end
  endtask

  // output held off long enough for the command queue to fill and stall input
  task automatic test_receiver_hold();
    fork
      hold_receiver(400);
    join_none
    repeat (7) send_cmd(make_cmd(OP_PRESENT, .pg($urandom_range(PAGES - 1))));
    wait_drained();
  endtask

  task automatic test_full_rate(int stop_at);
    steady = 1'b1;
    run_random_traffic(stop_at);
    steady = 1'b0;
  endtask

  initial begin
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.opcode      <= OP_FILL;
    in_ch.pos_x       <= '0;
    in_ch.pos_y       <= '0;
    in_ch.blit_width  <= '0;
    in_ch.blit_height <= '0;
    in_ch.value_byte  <= '0;
    in_ch.page_select <= '0;
    shadow_reset();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_after_reset();
    test_fill_and_pixel();
    test_blit_edges();
    test_receiver_hold();
    run_random_traffic(150);
    test_full_rate(180);

    wait_drained();
    repeat (300) @(posedge clk);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
